FILE: design/dra_pkg.sv
// Shared types, constants and the mod-9 reduction helper for the
// digital root accumulator. No dependencies.

package dra_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned RootW     = 4;
  // 2^6 == 1 (mod 9): a residue is a plain sum of 6-bit chunks
  localparam int unsigned ChunkW    = 6;
  localparam int unsigned NumChunks = (ValueW + ChunkW - 1) / ChunkW;
  localparam int unsigned CntW      = $clog2(NumChunks + 1);
  localparam int unsigned SumW      = ChunkW + 1;
  localparam int unsigned OutDataW  = ((ValueW + RootW + 7) / 8) * 8;

  typedef struct packed {
    logic busy;
    logic done;
  } mod9_status_t;

  // x mod 9 for x < 128; quotient by reciprocal 57/512
  function automatic logic [RootW-1:0] mod9_small(input logic [SumW-1:0] x);
    logic [SumW+5:0] prod;
    logic [SumW-1:0] q;
    logic [SumW-1:0] r;
    prod = {6'd0, x} * (SumW + 6)'(57);
    q    = SumW'(prod[SumW+5:9]);
    r    = x - ((q << 3) + q);
    return r[RootW-1:0];
  endfunction

endpackage

FILE: design/dra_mod9_unit.sv
// Serial digital root unit: folds a 64-bit operand 6 bits a cycle into a
// mod-9 residue, then maps the residue to a root. Depends on dra_pkg.

module dra_mod9_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dra_pkg::ValueW-1:0]  operand_i,
  output dra_pkg::mod9_status_t       status_o,
  output logic [dra_pkg::RootW-1:0]   root_o
);
  import dra_pkg::*;

  logic [ValueW-1:0] opnd_q, opnd_d;
  logic [RootW-1:0]  res_q, res_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              nz_q, nz_d;
  logic              done_q, done_d;
  logic [SumW-1:0]   step_sum;

  assign step_sum = {{(SumW-RootW){1'b0}}, res_q} + {1'b0, opnd_q[ChunkW-1:0]};

  always_comb begin
    opnd_d = opnd_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    nz_d   = nz_q;
    done_d = 1'b0;
    if (start_i) begin
      opnd_d = operand_i;
      res_d  = '0;
      cnt_d  = CntW'(NumChunks);
      nz_d   = |operand_i;
    end else if (cnt_q != '0) begin
      opnd_d = opnd_q >> ChunkW;
      res_d  = mod9_small(step_sum);
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    res_q  <= res_d;
    nz_q   <= nz_d;
  end

  // nonzero multiple of nine has root 9
  assign root_o = !nz_q ? '0 : ((res_q == '0) ? RootW'(9) : res_q);

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;

endmodule

FILE: design/digital_root_accumulator.sv
// Digital root accumulator top level: sequencer, accumulator and output
// register around one shared serial mod-9 unit. Depends on dra_pkg, dra_mod9_unit.
//
// Usage:
//   s_axis carries one 64-bit value per item in tdata, tlast marks the last
//   item of a set. m_axis returns one item per set: the wrapped 64-bit total
//   and its decimal digital root. cfg_data[0] selects the mode: 0 adds raw
//   values, 1 adds the digital root of each value. Write cfg only while idle.
// Sequence:
//   Raw mode, non-last item: next item taken the following cycle.
//   Root mode item: accept, the 11 chunk steps of the mod-9 unit, then the add.
//   Last item: then the root of the total (11 chunk steps, then done), then
//   the load into the output register from StPush once the register is free.
//   s_axis_tready is low while the mod-9 unit runs and while StPush waits.
// Reset:
//   Accumulator cleared, mode set to raw, output register empty.
// Stall:
//   A result waits in the output register; new items are still accepted
//   until the next total, which waits in StPush for the register to free up.

module digital_root_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dra_pkg::ValueW-1:0]    s_axis_tdata,   // [63:0] value
  input  logic                          s_axis_tlast,   // last_item
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dra_pkg::OutDataW-1:0]  m_axis_tdata,   // [63:0] total, [67:64] root
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data        // [0] sum_mode
);
  import dra_pkg::*;

  typedef enum logic [3:0] {
    StIdle      = 4'b0001,
    StRootItem  = 4'b0010,
    StRootTotal = 4'b0100,
    StPush      = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              mode_q;
  logic              last_q, last_d;
  logic              out_vld_q, out_vld_d;
  logic [ValueW-1:0] out_total_q, out_total_d;
  logic [RootW-1:0]  out_root_q, out_root_d;
  logic              unit_start;
  logic [ValueW-1:0] unit_opnd;
  mod9_status_t      unit_st;
  logic [RootW-1:0]  unit_root;
  logic              in_acc;
  logic              out_free;

  dra_mod9_unit u_mod9 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (unit_start),
    .operand_i (unit_opnd),
    .status_o  (unit_st),
    .root_o    (unit_root)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign cfg_ready     = 1'b1;

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    last_d      = last_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_total_d = out_total_q;
    out_root_d  = out_root_q;
    unit_start  = 1'b0;
    unit_opnd   = s_axis_tdata;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          last_d = s_axis_tlast;
          if (mode_q) begin
            unit_start = 1'b1;
            unit_opnd  = s_axis_tdata;
            state_d    = StRootItem;
          end else begin
            acc_d = acc_q + s_axis_tdata;
            if (s_axis_tlast) begin
              unit_start = 1'b1;
              unit_opnd  = acc_d;
              state_d    = StRootTotal;
            end
          end
        end
      end
      StRootItem: begin
        if (unit_st.done) begin
          acc_d = acc_q + {{(ValueW-RootW){1'b0}}, unit_root};
          if (last_q) begin
            unit_start = 1'b1;
            unit_opnd  = acc_d;
            state_d    = StRootTotal;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StRootTotal: begin
        if (unit_st.done) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_total_d = acc_q;
          out_root_d  = unit_root;
          acc_d       = '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      acc_q     <= '0;
      mode_q    <= 1'b0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      last_q    <= last_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid && cfg_ready) begin
        mode_q <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_total_q <= out_total_d;
    out_root_q  <= out_root_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-ValueW-RootW){1'b0}}, out_root_q, out_total_q};

  // the serial unit never runs while new items are taken
  a_ready_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !unit_st.busy)
    else $error("input ready while mod-9 unit busy");

  a_done_in_root_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_st.done |-> (state_q == StRootItem || state_q == StRootTotal))
    else $error("mod-9 unit finished outside a root state");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ValueW+RootW-1:ValueW] <= RootW'(9)))
    else $error("digital root out of range");

  a_push_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPush && out_free) |=> (m_axis_tvalid && acc_q == '0))
    else $error("total not handed to output register");

endmodule
